FILE: src/modular_exponentiation_assert.svh
// Assertion macros for the modular exponentiation block
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define MEXP_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modular_exponentiation: assertion failed");
// next-cycle implication
`define MEXP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modular_exponentiation: assertion failed");
`else
`define MEXP_ASSERT(label, ante, cons)
`define MEXP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: src/mexp_pkg.sv
// Shared types, constants and microcode program of the modular exponentiation block
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

    localparam int BASE_W = 30;
    localparam int EXP_W  = 63;
    localparam int RES_W  = 30;

    localparam int S_TDATA_W = ((BASE_W + EXP_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

    typedef logic [RES_W-1:0] residue_t;

    localparam residue_t    PRIME    = 30'd1000000007;
    localparam logic [31:0] PRIME_X2 = 32'd2000000014;

    // Barrett constant floor(2^60 / p), fits in 31 bits
    localparam logic [63:0] MU_WIDE = (64'd1 << 60) / 64'd1000000007;
    localparam logic [30:0] MU      = MU_WIDE[30:0];

    // stages from operand capture to result register in the multiplier
    localparam int MUL_LATENCY = 5;

    typedef logic [3:0] step_t;

    localparam step_t ST_WAIT    = 4'd0;
    localparam step_t ST_CHECK   = 4'd1;
    localparam step_t ST_MUL_ACC = 4'd2;
    localparam step_t ST_MUL_SQ  = 4'd3;
    localparam step_t ST_GAP0    = 4'd4;
    localparam step_t ST_GAP1    = 4'd5;
    localparam step_t ST_GAP2    = 4'd6;
    localparam step_t ST_WR_ACC  = 4'd7;
    localparam step_t ST_WR_SQ   = 4'd8;
    localparam step_t ST_DONE    = 4'd9;

    typedef enum logic [2:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NO_START,
        JC_EXP_ZERO,
        JC_OUT_BUSY
    } jcond_t;

    typedef enum logic {
        OPA_ACC,
        OPA_SQ
    } opa_t;

    typedef struct packed {
        logic   in_ready;
        logic   issue;
        opa_t   opa;
        logic   wr_acc;
        logic   wr_sq;
        logic   out_load;
        jcond_t cond;
        step_t  target;
        step_t  next_step;
    } ctrl_word_t;

    typedef struct packed {
        logic start;
        logic exp_zero;
        logic out_free;
    } status_t;

    // Program: one exponent bit per pass from CHECK to WR_SQ. The gap steps
    // cover the multiplier latency, so WR_ACC sees the product issued in MUL_ACC.
    function automatic ctrl_word_t ucode_rom(input step_t s);
        ctrl_word_t w;
        w           = '0;
        w.opa       = OPA_ACC;
        w.cond      = JC_NEVER;
        w.target    = ST_WAIT;
        w.next_step = ST_WAIT;
        unique case (s)
            ST_WAIT:
            begin
                w.in_ready  = 1'b1;
                w.cond      = JC_NO_START;
                w.target    = ST_WAIT;
                w.next_step = ST_CHECK;
            end
            ST_CHECK:
            begin
                w.cond      = JC_EXP_ZERO;
                w.target    = ST_DONE;
                w.next_step = ST_MUL_ACC;
            end
            ST_MUL_ACC:
            begin
                w.issue     = 1'b1;
                w.opa       = OPA_ACC;
                w.next_step = ST_MUL_SQ;
            end
            ST_MUL_SQ:
            begin
                w.issue     = 1'b1;
                w.opa       = OPA_SQ;
                w.next_step = ST_GAP0;
            end
            ST_GAP0:
            begin
                w.next_step = ST_GAP1;
            end
            ST_GAP1:
            begin
                w.next_step = ST_GAP2;
            end
            ST_GAP2:
            begin
                w.next_step = ST_WR_ACC;
            end
            ST_WR_ACC:
            begin
                w.wr_acc    = 1'b1;
                w.next_step = ST_WR_SQ;
            end
            ST_WR_SQ:
            begin
                w.wr_sq     = 1'b1;
                w.cond      = JC_ALWAYS;
                w.target    = ST_CHECK;
                w.next_step = ST_CHECK;
            end
            ST_DONE:
            begin
                w.out_load  = 1'b1;
                w.cond      = JC_OUT_BUSY;
                w.target    = ST_DONE;
                w.next_step = ST_WAIT;
            end
            default:
            begin
                w.cond   = JC_ALWAYS;
                w.target = ST_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: src/modular_exponentiation.sv
// Top level: base^exponent mod 1000000007 by right-to-left binary exponentiation
//
//  channel  | dir | handshake                     | payload
//  ---------+-----+-------------------------------+----------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | base_value, exponent_value
//  m_axis   | out | m_axis_tvalid / m_axis_tready | power_result
//
// One transaction at a time: after acceptance the result takes one pass per bit of the
// exponent's bit length n (no pass for a zero exponent, n at most 63).
// Each exponent bit is one eight-step microcode pass sharing the five-stage modular
// multiplier between the product and the square.
// The next transaction is taken once the result sits in the output register.
// Reset clears the step counter and the output valid; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "modular_exponentiation_assert.svh"

module modular_exponentiation
    import mexp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [29:0] base_value, [92:30] exponent_value, [95:93] zero
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [29:0] power_result, [31:30] zero
    output logic [M_TDATA_W-1:0]      m_axis_tdata
);

    ctrl_word_t cw;
    status_t    status;

    residue_t         acc_reg;
    residue_t         sq_reg;
    logic [EXP_W-1:0] exp_reg;
    logic             out_valid_reg;
    residue_t         out_reg;

    logic             in_fire;
    logic             out_free;
    logic             out_wr;
    residue_t         base_in;
    residue_t         base_red;
    residue_t         mul_a;
    logic             mul_valid;
    residue_t         mul_res;

    assign base_in  = s_axis_tdata[BASE_W-1:0];
    assign base_red = (base_in >= PRIME) ? base_in - PRIME : base_in;

    assign s_axis_tready = cw.in_ready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign out_wr        = cw.out_load && out_free;

    assign status.start    = s_axis_tvalid;
    assign status.exp_zero = (exp_reg == '0);
    assign status.out_free = out_free;

    mexp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cw     (cw)
    );

    assign mul_a = (cw.opa == OPA_SQ) ? sq_reg : acc_reg;

    mexp_modmul u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .issue  (cw.issue),
        .a      (mul_a),
        .b      (sq_reg),
        .valid  (mul_valid),
        .result (mul_res)
    );

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            acc_reg <= RES_W'(1);
            sq_reg  <= base_red;
            exp_reg <= s_axis_tdata[BASE_W+EXP_W-1:BASE_W];
        end
        else
        begin
            if (cw.wr_acc && exp_reg[0])
            begin
                acc_reg <= mul_res;
            end
            if (cw.wr_sq)
            begin
                sq_reg  <= mul_res;
                exp_reg <= {1'b0, exp_reg[EXP_W-1:1]};
            end
        end
        if (out_wr)
        begin
            out_reg <= acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_wr)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W-RES_W)'(0), out_reg};

    // microcode write-back steps must line up with the multiplier latency
    `MEXP_ASSERT(a_wb_aligned, cw.wr_acc || cw.wr_sq, mul_valid)
    `MEXP_ASSERT_NEXT(a_single_item, in_fire, !s_axis_tready)
    `MEXP_ASSERT(a_state_reduced, !s_axis_tready, (acc_reg < PRIME) && (sq_reg < PRIME))
    `MEXP_ASSERT(a_result_reduced, m_axis_tvalid, out_reg < PRIME)

endmodule

`default_nettype wire

FILE: src/mexp_modmul.sv
// Pipelined multiplier modulo the prime, Barrett reduction
`timescale 1ns / 1ps
`default_nettype none

module mexp_modmul
    import mexp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     issue,
    input  wire residue_t a,
    input  wire residue_t b,
    output logic          valid,
    output residue_t      result
);

    logic [MUL_LATENCY-1:0] vld_reg;
    logic [MUL_LATENCY-1:0] vld_next;

    logic [2*RES_W-1:0] prod_reg;
    logic [61:0]        est_reg;
    logic [31:0]        lo2_reg;
    logic [31:0]        qp_reg;
    logic [31:0]        lo3_reg;
    logic [31:0]        rem_reg;
    residue_t           res_reg;

    logic [60:0] qp_full;
    logic [31:0] rem_m1;
    logic [31:0] rem_m2;
    residue_t    res_next;

    assign vld_next = {vld_reg[MUL_LATENCY-2:0], issue};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // q = floor(floor(x / 2^29) * mu / 2^31) undershoots by at most two
    assign qp_full = 61'(est_reg[61:31]) * 61'(PRIME);

    assign rem_m1 = rem_reg - 32'(PRIME);
    assign rem_m2 = rem_reg - PRIME_X2;

    always_comb
    begin
        if (rem_reg >= PRIME_X2)
        begin
            res_next = rem_m2[RES_W-1:0];
        end
        else if (rem_reg >= 32'(PRIME))
        begin
            res_next = rem_m1[RES_W-1:0];
        end
        else
        begin
            res_next = rem_reg[RES_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= (2*RES_W)'(a) * (2*RES_W)'(b);
        est_reg  <= 62'(prod_reg[59:29]) * 62'(MU);
        lo2_reg  <= prod_reg[31:0];
        qp_reg   <= qp_full[31:0];
        lo3_reg  <= lo2_reg;
        rem_reg  <= lo3_reg - qp_reg;
        res_reg  <= res_next;
    end

    assign valid  = vld_reg[MUL_LATENCY-1];
    assign result = res_reg;

endmodule

`default_nettype wire

FILE: src/mexp_ctrl.sv
// Microcode sequencer: step counter, program ROM and jump logic
`timescale 1ns / 1ps
`default_nettype none

module mexp_ctrl
    import mexp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire status_t status,
    output ctrl_word_t   cw
);

    step_t step_reg;
    step_t step_next;
    logic  take;

    assign cw = ucode_rom(step_reg);

    always_comb
    begin
        unique case (cw.cond)
            JC_NEVER:    take = 1'b0;
            JC_ALWAYS:   take = 1'b1;
            JC_NO_START: take = !status.start;
            JC_EXP_ZERO: take = status.exp_zero;
            JC_OUT_BUSY: take = !status.out_free;
            default:     take = 1'b1;
        endcase
        step_next = take ? cw.target : cw.next_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire
